// ===== hw/rtl/btbp_pkg.sv =====
package btbp_pkg;

   // Widths of the channel fields
   localparam int ADDR_FIELD_WIDTH = 64;
   localparam int POS_FIELD_WIDTH  = 4;

   // Fall-through step when no entry matches
   localparam int STEP_BYTES = 4;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_WAIT,
      ST_UPDATE
   } state_type;

   // Table-wide update strobes, broadcast to every cell
   typedef struct packed {
      logic flush;
      logic write;
      logic executed;
   } ctl_type;

   // Flags of the lookup token that walks down the row
   typedef struct packed {
      logic valid;
      logic hit;
      logic exec;
      logic scan;
      logic seen;
      logic blocked;
   } tok_type;

endpackage

// ===== hw/rtl/btbp_if.sv =====
interface btbp_req_if;
   import btbp_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        flush;
   logic                        write_enable;
   logic                        executed;
   logic [ADDR_FIELD_WIDTH-1:0] write_pc;
   logic [ADDR_FIELD_WIDTH-1:0] write_target;
   logic [ADDR_FIELD_WIDTH-1:0] predict_pc;

   modport source (
      output valid, flush, write_enable, executed, write_pc, write_target, predict_pc,
      input  ready
   );
   modport sink (
      input  valid, flush, write_enable, executed, write_pc, write_target, predict_pc,
      output ready
   );
endinterface

interface btbp_rsp_if;
   import btbp_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [POS_FIELD_WIDTH-1:0]  position;
   logic [ADDR_FIELD_WIDTH-1:0] predicted_address;
   logic                        was_executed;
   logic                        last;

   modport source (
      output valid, position, predicted_address, was_executed, last,
      input  ready
   );
   modport sink (
      input  valid, position, predicted_address, was_executed, last,
      output ready
   );
endinterface

// ===== hw/rtl/btbp_cell.sv =====
module btbp_cell #(
   parameter int ADDR_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  btbp_pkg::ctl_type     ctl,
   input  logic [ADDR_WIDTH-1:0] wr_pc,
   input  btbp_pkg::tok_type     tok_in,
   input  logic [ADDR_WIDTH-1:0] tok_in_addr,
   input  logic [ADDR_WIDTH-1:0] tok_in_tgt,
   output btbp_pkg::tok_type     tok_out,
   output logic [ADDR_WIDTH-1:0] tok_out_addr,
   output logic [ADDR_WIDTH-1:0] tok_out_tgt,
   input  logic [ADDR_WIDTH-1:0] ent_in_pc,
   input  logic [ADDR_WIDTH-1:0] ent_in_tgt,
   input  logic                  ent_in_exe,
   output logic [ADDR_WIDTH-1:0] ent_pc,
   output logic [ADDR_WIDTH-1:0] ent_tgt,
   output logic                  ent_exe
);
   import btbp_pkg::*;

   logic [ADDR_WIDTH-1:0] pc_ff,  pc_in;
   logic [ADDR_WIDTH-1:0] tgt_ff, tgt_in;
   logic                  exe_ff, exe_in;
   logic                  shift_ff, shift_in;
   tok_type               tok_ff, tok_in_nx;
   logic [ADDR_WIDTH-1:0] taddr_ff, taddr_in;
   logic [ADDR_WIDTH-1:0] ttgt_ff, ttgt_in;
   logic                  look_match;
   logic                  write_match;

   assign look_match  = (pc_ff == tok_in_addr);
   assign write_match = (pc_ff == wr_pc);

   // Token stage: first match wins, the write scan notes earlier copies
   always_comb begin
      tok_in_nx = tok_in;
      taddr_in  = tok_in_addr;
      ttgt_in   = tok_in_tgt;
      shift_in  = shift_ff;
      if (tok_in.valid && !tok_in.hit && look_match) begin
         tok_in_nx.hit  = 1'b1;
         tok_in_nx.exec = exe_ff;
         ttgt_in        = tgt_ff;
      end
      if (tok_in.valid && tok_in.scan) begin
         // shift only if no copy of the pc sits above this slot
         shift_in       = !tok_in.seen;
         tok_in_nx.seen = tok_in.seen | write_match;
         if (write_match) begin
            tok_in_nx.blocked = exe_ff & !ctl.executed;
         end
      end
   end

   // Entry: cleared on flush, takes the upper neighbour's entry on a write when its shift flag is set
   always_comb begin
      pc_in  = pc_ff;
      tgt_in = tgt_ff;
      exe_in = exe_ff;
      if (ctl.flush) begin
         pc_in  = '0;
         tgt_in = '0;
         exe_in = 1'b0;
      end else if (ctl.write && shift_ff) begin
         pc_in  = ent_in_pc;
         tgt_in = ent_in_tgt;
         exe_in = ent_in_exe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         tgt_ff <= '0;
         exe_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         tgt_ff <= tgt_in;
         exe_ff <= exe_in;
         tok_ff <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      taddr_ff <= taddr_in;
      ttgt_ff  <= ttgt_in;
      shift_ff <= shift_in;
   end

   assign tok_out      = tok_ff;
   assign tok_out_addr = taddr_ff;
   assign tok_out_tgt  = ttgt_ff;
   assign ent_pc       = pc_ff;
   assign ent_tgt      = tgt_ff;
   assign ent_exe      = exe_ff;

endmodule

// ===== hw/rtl/btbp_ctrl.sv =====
module btbp_ctrl #(
   parameter int ADDR_WIDTH = 64,
   parameter int DEPTH      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   btbp_req_if.sink              req_if,
   btbp_rsp_if.source            rsp_if,
   output btbp_pkg::ctl_type     ctl,
   output logic [ADDR_WIDTH-1:0] wr_pc,
   output logic [ADDR_WIDTH-1:0] wr_tgt,
   output btbp_pkg::tok_type     tok_head,
   output logic [ADDR_WIDTH-1:0] tok_head_addr,
   output logic [ADDR_WIDTH-1:0] tok_head_tgt,
   input  btbp_pkg::tok_type     tok_tail,
   input  logic [ADDR_WIDTH-1:0] tok_tail_addr,
   input  logic [ADDR_WIDTH-1:0] tok_tail_tgt
);
   import btbp_pkg::*;

   localparam int POS_W = $clog2(DEPTH);

   state_type             state_ff, state_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic                  hexe_ff, hexe_in;
   logic                  blocked_ff, blocked_in;
   logic                  flush_ff, flush_in;
   logic                  we_ff, we_in;
   logic                  ex_ff, ex_in;
   logic [ADDR_WIDTH-1:0] wpc_ff, wpc_in;
   logic [ADDR_WIDTH-1:0] wtgt_ff, wtgt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [ADDR_WIDTH-1:0] rsp_addr_ff, rsp_addr_in;
   logic                  rsp_exe_ff, rsp_exe_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic req_take;
   logic out_free;
   logic is_last;
   logic emit_load;
   logic inject;
   logic do_update;

   assign req_take = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign is_last  = (pos_ff == POS_W'(DEPTH - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = is_last ? ST_UPDATE : ST_WAIT;
         end
         ST_WAIT: begin
            if (tok_tail.valid) state_in = ST_EMIT;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs
   always_comb begin
      req_if.ready = 1'b0;
      emit_load    = 1'b0;
      inject       = 1'b0;
      do_update    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ST_EMIT: begin
            emit_load = out_free;
            inject    = out_free && !is_last;
         end
         ST_WAIT: begin
         end
         ST_UPDATE: begin
            do_update = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Item registers and chain walk
   always_comb begin
      pos_in     = pos_ff;
      addr_in    = addr_ff;
      hexe_in    = hexe_ff;
      blocked_in = blocked_ff;
      flush_in   = flush_ff;
      we_in      = we_ff;
      ex_in      = ex_ff;
      wpc_in     = wpc_ff;
      wtgt_in    = wtgt_ff;
      if (req_take) begin
         pos_in   = '0;
         addr_in  = req_if.predict_pc[ADDR_WIDTH-1:0];
         hexe_in  = req_if.executed;
         flush_in = req_if.flush;
         we_in    = req_if.write_enable;
         ex_in    = req_if.executed;
         wpc_in   = req_if.write_pc[ADDR_WIDTH-1:0];
         wtgt_in  = req_if.write_target[ADDR_WIDTH-1:0];
      end
      if (inject) begin
         pos_in = pos_ff + POS_W'(1);
      end
      if ((state_ff == ST_WAIT) && tok_tail.valid) begin
         // hit takes the stored target, a miss falls through by one word
         addr_in = tok_tail.hit ? tok_tail_tgt
                                : tok_tail_addr + ADDR_WIDTH'(STEP_BYTES);
         hexe_in = tok_tail.hit & tok_tail.exec;
         if (tok_tail.scan) blocked_in = tok_tail.blocked;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_exe_in   = rsp_exe_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_ff;
         rsp_addr_in  = addr_ff;
         rsp_exe_in   = hexe_ff;
         rsp_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      addr_ff     <= addr_in;
      hexe_ff     <= hexe_in;
      blocked_ff  <= blocked_in;
      flush_ff    <= flush_in;
      we_ff       <= we_in;
      ex_ff       <= ex_in;
      wpc_ff      <= wpc_in;
      wtgt_ff     <= wtgt_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_exe_ff  <= rsp_exe_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Token launched into the head of the row; the first pass also scans for the write
   always_comb begin
      tok_head         = '0;
      tok_head.valid   = inject;
      tok_head.scan    = (pos_ff == '0);
   end
   assign tok_head_addr = addr_ff;
   assign tok_head_tgt  = '0;

   assign ctl.flush    = do_update && flush_ff;
   assign ctl.write    = do_update && we_ff && !blocked_ff;
   assign ctl.executed = ex_ff;
   assign wr_pc        = wpc_ff;
   assign wr_tgt       = wtgt_ff;

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.position          = POS_FIELD_WIDTH'(rsp_pos_ff);
   assign rsp_if.predicted_address = ADDR_FIELD_WIDTH'(rsp_addr_ff);
   assign rsp_if.was_executed      = rsp_exe_ff;
   assign rsp_if.last              = rsp_last_ff;

endmodule

// ===== hw/rtl/branch_target_buffer_predictor_unit.sv =====
// Channel   Dir  Words per item  Payload
// req_if    in   1               flush, write_enable, executed, write_pc, write_target,
//                                predict_pc
// rsp_if    out  DEPTH           position, predicted_address, was_executed, last
//
// Each chain step but the last sends a lookup token down the row of ENTRIES
// cells, one cell a cycle.
// The table update is applied in the UPDATE state, after the last word is loaded.
// Synchronous reset clears the table and empties the result register.
// A stall on rsp_if holds the sequencer; req_if is ready only between items.
module branch_target_buffer_predictor_unit #(
   parameter int ENTRIES    = 8,
   parameter int DEPTH      = 5,
   parameter int ADDR_WIDTH = 64
) (
   input logic        clock,
   input logic        reset,
   btbp_req_if.sink   req_if,
   btbp_rsp_if.source rsp_if
);
   import btbp_pkg::*;

   ctl_type               ctl;
   logic [ADDR_WIDTH-1:0] wr_pc;
   logic [ADDR_WIDTH-1:0] wr_tgt;

   // Token links: element 0 is the head, element k+1 leaves cell k
   tok_type               tok       [ENTRIES+1];
   logic [ADDR_WIDTH-1:0] tok_addr  [ENTRIES+1];
   logic [ADDR_WIDTH-1:0] tok_tgt   [ENTRIES+1];

   // Entry links for the shift on a write
   logic [ADDR_WIDTH-1:0] ent_pc    [ENTRIES];
   logic [ADDR_WIDTH-1:0] ent_tgt   [ENTRIES];
   logic                  ent_exe   [ENTRIES];

   btbp_ctrl #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .DEPTH      (DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .ctl           (ctl),
      .wr_pc         (wr_pc),
      .wr_tgt        (wr_tgt),
      .tok_head      (tok[0]),
      .tok_head_addr (tok_addr[0]),
      .tok_head_tgt  (tok_tgt[0]),
      .tok_tail      (tok[ENTRIES]),
      .tok_tail_addr (tok_addr[ENTRIES]),
      .tok_tail_tgt  (tok_tgt[ENTRIES])
   );

   // Row of cells, slot 0 holds the most recent write
   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      logic [ADDR_WIDTH-1:0] up_pc;
      logic [ADDR_WIDTH-1:0] up_tgt;
      logic                  up_exe;

      if (k == 0) begin : g_head
         assign up_pc  = wr_pc;
         assign up_tgt = wr_tgt;
         assign up_exe = ctl.executed;
      end else begin : g_body
         assign up_pc  = ent_pc[k-1];
         assign up_tgt = ent_tgt[k-1];
         assign up_exe = ent_exe[k-1];
      end

      btbp_cell #(
         .ADDR_WIDTH (ADDR_WIDTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .wr_pc        (wr_pc),
         .tok_in       (tok[k]),
         .tok_in_addr  (tok_addr[k]),
         .tok_in_tgt   (tok_tgt[k]),
         .tok_out      (tok[k+1]),
         .tok_out_addr (tok_addr[k+1]),
         .tok_out_tgt  (tok_tgt[k+1]),
         .ent_in_pc    (up_pc),
         .ent_in_tgt   (up_tgt),
         .ent_in_exe   (up_exe),
         .ent_pc       (ent_pc[k]),
         .ent_tgt      (ent_tgt[k]),
         .ent_exe      (ent_exe[k])
      );
   end

endmodule
